### rtl/core/aamm_pkg.sv
package aamm_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    // degree-to-turn factor, 2^64 * 3.1415926 / (360 * pi), rounded
    localparam logic [63:0] TURN_CQ = 64'd51240954886227837;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    localparam logic [3:0] LAST_POS = 4'd15;

    // one queued request, already split up by the front end
    typedef struct packed {
        logic               angle_neg;
        logic [31:0]        angle_mag;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [31:0]        axis_max;
        logic               axis_zero;
        logic [31:0]        shift_x;
        logic [31:0]        shift_y;
        logic [31:0]        shift_z;
    } item_t;

    // finished matrix: nine rotation words, three translation words
    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][31:0] shift;
    } mat_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            5'd31: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/aamm_front.sv
module aamm_front
    import aamm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    output item_t        item,
    output logic         item_valid,
    input  logic         item_take
);

    item_t       cls;
    logic [31:0] mag_x, mag_y, mag_z, mag_xy;
    logic signed [31:0] deg;

    item_t       q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    always_comb
    begin
        deg          = s_axis_tdata[31:0];
        cls.axis_x   = s_axis_tdata[63:32];
        cls.axis_y   = s_axis_tdata[95:64];
        cls.axis_z   = s_axis_tdata[127:96];
        cls.shift_x  = s_axis_tdata[159:128];
        cls.shift_y  = s_axis_tdata[191:160];
        cls.shift_z  = s_axis_tdata[223:192];
        cls.angle_neg = deg[31];
        cls.angle_mag = deg[31] ? 32'(-deg) : deg;
        mag_x  = cls.axis_x[31] ? 32'(-cls.axis_x) : cls.axis_x;
        mag_y  = cls.axis_y[31] ? 32'(-cls.axis_y) : cls.axis_y;
        mag_z  = cls.axis_z[31] ? 32'(-cls.axis_z) : cls.axis_z;
        mag_xy = (mag_y > mag_x) ? mag_y : mag_x;
        cls.axis_max  = (mag_z > mag_xy) ? mag_z : mag_xy;
        cls.axis_zero = (cls.axis_max == 32'd0);
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (cnt_reg != 2'd0);
    assign pop           = item_take && item_valid;
    assign item          = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/aamm_engine.sv
module aamm_engine
    import aamm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  item_valid,
    output logic  item_take,
    output mat_t  mat,
    output logic  mat_valid,
    input  logic  emit_busy
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int SH    = 30 - FRAC_BITS;
    localparam logic [63:0] HALF_PH = 64'd1 << (FRAC_BITS - 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_PH0   = 5'd1;
    localparam logic [4:0] ST_PH1   = 5'd2;
    localparam logic [4:0] ST_PH2   = 5'd3;
    localparam logic [4:0] ST_PH3   = 5'd4;
    localparam logic [4:0] ST_NORM  = 5'd5;
    localparam logic [4:0] ST_SQ    = 5'd6;
    localparam logic [4:0] ST_SQRT  = 5'd7;
    localparam logic [4:0] ST_SQRTF = 5'd8;
    localparam logic [4:0] ST_DIVI  = 5'd9;
    localparam logic [4:0] ST_DIV   = 5'd10;
    localparam logic [4:0] ST_DIVF  = 5'd11;
    localparam logic [4:0] ST_WAIT  = 5'd12;
    localparam logic [4:0] ST_MUL   = 5'd13;
    localparam logic [4:0] ST_SUM   = 5'd14;
    localparam logic [4:0] ST_WORD  = 5'd15;
    localparam logic [4:0] ST_HAND  = 5'd16;

    function automatic logic [31:0] to_word(input logic signed [34:0] v);
        logic [34:0] mag;
        logic [34:0] r;
        mag = v[34] ? 35'(-v) : $unsigned(v);
        r   = (mag + (35'd1 << (SH - 1))) >> SH;
        if (v[34])
        begin
            if (r > 35'h080000000)
            begin
                r = 35'h080000000;
            end
            return 32'(32'd0 - r[31:0]);
        end
        if (r > 35'h07FFFFFFF)
        begin
            r = 35'h07FFFFFFF;
        end
        return r[31:0];
    endfunction

    logic [4:0]  state_reg;
    item_t       it_reg;

    // shared multiplier
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod_reg;
    logic signed [67:0] rsum;
    logic signed [33:0] rnd;

    // angle to phase
    logic [55:0] hiprod_reg;
    logic [31:0] phase_reg;
    logic [63:0] ph_t;
    logic [31:0] ph_p;
    logic signed [33:0] ph_z;

    // CORDIC
    logic               c_run_reg;
    logic [CNT_W-1:0]   c_cnt_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [33:0] cs_reg, sn_reg;
    logic [4:0]         ci;
    logic signed [33:0] c_dx, c_dy, c_at;

    // normalization
    logic signed [32:0] n_reg [3];
    logic [31:0]        amax_reg;
    logic [63:0]        sumsq_reg;
    logic [1:0]         sq_cnt_reg;

    // square root
    logic [63:0] sv_reg, sr_reg, sbit_reg;
    logic [4:0]  scnt_reg;
    logic [63:0] s_rb;
    logic [31:0] len_reg;

    // divide lanes
    logic [31:0] drem_reg [3];
    logic [30:0] dlow_reg [3];
    logic [30:0] dq_reg [3];
    logic        dneg_reg [3];
    logic [4:0]  dcnt_reg;

    logic signed [33:0] u_reg [3];
    logic signed [33:0] omc_reg;
    logic signed [33:0] tmp_reg [15];
    logic signed [33:0] omt_reg [3];
    logic [3:0]         mcnt_reg;
    logic [3:0]         widx;
    logic signed [34:0] msum_reg [9];
    logic [31:0]        word_reg [9];

    assign item_take = (state_reg == ST_IDLE) && item_valid;
    assign mat_valid = (state_reg == ST_HAND);

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            mat.rot[k] = word_reg[k];
        end
        mat.shift[0] = it_reg.shift_x;
        mat.shift[1] = it_reg.shift_y;
        mat.shift[2] = it_reg.shift_z;
    end

    // multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        priority case (1'b1)
            state_reg == ST_PH0:
            begin
                op_a = $signed({2'b00, it_reg.angle_mag});
                op_b = $signed({2'b00, TURN_CQ[63:32]});
            end
            state_reg == ST_PH1:
            begin
                op_a = $signed({2'b00, it_reg.angle_mag});
                op_b = $signed({2'b00, TURN_CQ[31:0]});
            end
            state_reg == ST_SQ:
            begin
                unique case (sq_cnt_reg)
                    2'd0:    op_a = 34'(n_reg[0]);
                    2'd1:    op_a = 34'(n_reg[1]);
                    2'd2:    op_a = 34'(n_reg[2]);
                    default: op_a = '0;
                endcase
                op_b = op_a;
            end
            state_reg == ST_MUL:
            begin
                unique case (mcnt_reg)
                    4'd0:  begin op_a = u_reg[0];    op_b = u_reg[1];   end
                    4'd1:  begin op_a = u_reg[1];    op_b = u_reg[2];   end
                    4'd2:  begin op_a = u_reg[2];    op_b = u_reg[0];   end
                    4'd3:  begin op_a = u_reg[0];    op_b = sn_reg;     end
                    4'd4:  begin op_a = u_reg[1];    op_b = sn_reg;     end
                    4'd5:  begin op_a = u_reg[2];    op_b = sn_reg;     end
                    4'd6:  begin op_a = u_reg[0];    op_b = u_reg[0];   end
                    4'd7:  begin op_a = u_reg[1];    op_b = u_reg[1];   end
                    4'd8:  begin op_a = u_reg[2];    op_b = u_reg[2];   end
                    4'd9:  begin op_a = tmp_reg[0];  op_b = omc_reg;    end
                    4'd10: begin op_a = tmp_reg[1];  op_b = omc_reg;    end
                    4'd11: begin op_a = tmp_reg[2];  op_b = omc_reg;    end
                    4'd12: begin op_a = cs_reg;      op_b = omt_reg[0]; end
                    4'd13: begin op_a = cs_reg;      op_b = omt_reg[1]; end
                    4'd14: begin op_a = cs_reg;      op_b = omt_reg[2]; end
                    default: begin op_a = '0;        op_b = '0;         end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Q2.30 product rounding: (p + 2^29) >> 30, floor
    assign rsum = prod_reg + 68'sd536870912;
    assign rnd  = rsum[63:30];
    assign widx = mcnt_reg - 4'd1;

    always_comb
    begin
        ph_t = {8'd0, hiprod_reg} + {32'd0, prod_reg[63:32]} + HALF_PH;
        ph_p = it_reg.angle_neg ? 32'(32'd0 - phase_reg) : phase_reg;
        ph_z = 34'($signed(ph_p));
        ci   = c_cnt_reg[4:0];
        c_dx = cy_reg >>> ci;
        c_dy = cx_reg >>> ci;
        c_at = $signed({2'b00, atan_turn(ci)});
        s_rb = sr_reg + sbit_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        unique case (state_reg)
            ST_IDLE:
            begin
                it_reg <= item;
            end
            ST_PH1:
            begin
                hiprod_reg <= prod_reg[55:0];
            end
            ST_PH2:
            begin
                phase_reg <= 32'(ph_t >> FRAC_BITS);
            end
            ST_PH3:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    u_reg[k] <= '0;
                end
                n_reg[0] <= 33'(it_reg.axis_x);
                n_reg[1] <= 33'(it_reg.axis_y);
                n_reg[2] <= 33'(it_reg.axis_z);
                amax_reg <= it_reg.axis_max;
            end
            ST_NORM:
            begin
                if (amax_reg[31:30] == 2'd0)
                begin
                    if (amax_reg[29:22] == 8'd0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            n_reg[k] <= n_reg[k] <<< 8;
                        end
                        amax_reg <= amax_reg << 8;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            n_reg[k] <= n_reg[k] <<< 1;
                        end
                        amax_reg <= amax_reg << 1;
                    end
                end
                sumsq_reg <= '0;
            end
            ST_SQ:
            begin
                if (sq_cnt_reg != 2'd0)
                begin
                    sumsq_reg <= sumsq_reg + prod_reg[63:0];
                end
                sv_reg   <= sumsq_reg + prod_reg[63:0];
                sr_reg   <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            ST_SQRT:
            begin
                if (sv_reg >= s_rb)
                begin
                    sv_reg <= sv_reg - s_rb;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            ST_SQRTF:
            begin
                len_reg <= (sv_reg > sr_reg) ? sr_reg[31:0] + 32'd1 : sr_reg[31:0];
            end
            ST_DIVI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [31:0] mag;
                    logic [61:0] num;
                    mag = n_reg[k][32] ? 32'(-n_reg[k]) : n_reg[k][31:0];
                    num = {mag, 30'd0} + {31'd0, len_reg[31:1]};
                    drem_reg[k] <= {1'b0, num[61:31]};
                    dlow_reg[k] <= num[30:0];
                    dq_reg[k]   <= '0;
                    dneg_reg[k] <= n_reg[k][32];
                end
            end
            ST_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [32:0] tr;
                    tr = {drem_reg[k], dlow_reg[k][30]};
                    if (tr >= {1'b0, len_reg})
                    begin
                        drem_reg[k] <= 32'(tr - {1'b0, len_reg});
                        dq_reg[k]   <= {dq_reg[k][29:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[k] <= tr[31:0];
                        dq_reg[k]   <= {dq_reg[k][29:0], 1'b0};
                    end
                    dlow_reg[k] <= {dlow_reg[k][29:0], 1'b0};
                end
            end
            ST_DIVF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    u_reg[k] <= dneg_reg[k] ? -$signed({3'b000, dq_reg[k]})
                                            :  $signed({3'b000, dq_reg[k]});
                end
            end
            ST_WAIT:
            begin
                omc_reg <= ONE_Q30 - cs_reg;
            end
            ST_MUL:
            begin
                if (mcnt_reg != 4'd0)
                begin
                    tmp_reg[widx] <= rnd;
                    if (widx == 4'd6)
                    begin
                        omt_reg[0] <= ONE_Q30 - rnd;
                    end
                    if (widx == 4'd7)
                    begin
                        omt_reg[1] <= ONE_Q30 - rnd;
                    end
                    if (widx == 4'd8)
                    begin
                        omt_reg[2] <= ONE_Q30 - rnd;
                    end
                end
            end
            ST_SUM:
            begin
                // rows of the rotation, row-major
                msum_reg[0] <= 35'(tmp_reg[6]) + 35'(tmp_reg[12]);
                msum_reg[1] <= 35'(tmp_reg[9]) + 35'(tmp_reg[5]);
                msum_reg[2] <= 35'(tmp_reg[11]) - 35'(tmp_reg[4]);
                msum_reg[3] <= 35'(tmp_reg[9]) - 35'(tmp_reg[5]);
                msum_reg[4] <= 35'(tmp_reg[7]) + 35'(tmp_reg[13]);
                msum_reg[5] <= 35'(tmp_reg[10]) + 35'(tmp_reg[3]);
                msum_reg[6] <= 35'(tmp_reg[11]) + 35'(tmp_reg[4]);
                msum_reg[7] <= 35'(tmp_reg[10]) - 35'(tmp_reg[3]);
                msum_reg[8] <= 35'(tmp_reg[8]) + 35'(tmp_reg[14]);
            end
            ST_WORD:
            begin
                for (int k = 0; k < 9; k++)
                begin
                    word_reg[k] <= to_word(msum_reg[k]);
                end
            end
            default:
            begin
            end
        endcase

        // CORDIC datapath
        if (state_reg == ST_PH3)
        begin
            cx_reg <= CORDIC_GAIN;
            cy_reg <= '0;
            if (ph_z > 34'sd1073741824)
            begin
                cz_reg   <= ph_z - 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else if (ph_z < -34'sd1073741824)
            begin
                cz_reg   <= ph_z + 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= ph_z;
                flip_reg <= 1'b0;
            end
        end
        else if (c_run_reg)
        begin
            if (c_cnt_reg == CNT_W'(CORDIC_STEPS))
            begin
                cs_reg <= flip_reg ? -cx_reg : cx_reg;
                sn_reg <= flip_reg ? -cy_reg : cy_reg;
            end
            else if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - c_dx;
                cy_reg <= cy_reg + c_dy;
                cz_reg <= cz_reg - c_at;
            end
            else
            begin
                cx_reg <= cx_reg + c_dx;
                cy_reg <= cy_reg - c_dy;
                cz_reg <= cz_reg + c_at;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            c_run_reg  <= 1'b0;
            c_cnt_reg  <= '0;
            sq_cnt_reg <= 2'd0;
            scnt_reg   <= 5'd0;
            dcnt_reg   <= 5'd0;
            mcnt_reg   <= 4'd0;
        end
        else
        begin
            if (state_reg == ST_PH3)
            begin
                c_run_reg <= 1'b1;
                c_cnt_reg <= '0;
            end
            else if (c_run_reg)
            begin
                if (c_cnt_reg == CNT_W'(CORDIC_STEPS))
                begin
                    c_run_reg <= 1'b0;
                end
                else
                begin
                    c_cnt_reg <= c_cnt_reg + CNT_W'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= ST_PH0;
                    end
                end
                ST_PH0:  state_reg <= ST_PH1;
                ST_PH1:  state_reg <= ST_PH2;
                ST_PH2:  state_reg <= ST_PH3;
                ST_PH3:  state_reg <= it_reg.axis_zero ? ST_WAIT : ST_NORM;
                ST_NORM:
                begin
                    if (amax_reg[31:30] != 2'd0)
                    begin
                        state_reg  <= ST_SQ;
                        sq_cnt_reg <= 2'd0;
                    end
                end
                ST_SQ:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_SQRT;
                        scnt_reg  <= 5'd0;
                    end
                end
                ST_SQRT:
                begin
                    scnt_reg <= scnt_reg + 5'd1;
                    if (scnt_reg == 5'd31)
                    begin
                        state_reg <= ST_SQRTF;
                    end
                end
                ST_SQRTF: state_reg <= ST_DIVI;
                ST_DIVI:
                begin
                    state_reg <= ST_DIV;
                    dcnt_reg  <= 5'd0;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd30)
                    begin
                        state_reg <= ST_DIVF;
                    end
                end
                ST_DIVF: state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (!c_run_reg)
                    begin
                        state_reg <= ST_MUL;
                        mcnt_reg  <= 4'd0;
                    end
                end
                ST_MUL:
                begin
                    mcnt_reg <= mcnt_reg + 4'd1;
                    if (mcnt_reg == 4'd15)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:  state_reg <= ST_WORD;
                ST_WORD: state_reg <= ST_HAND;
                ST_HAND:
                begin
                    if (!emit_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // sine and cosine must be settled before the product sequence reads them
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> !c_run_reg)
        else $error("product sequence running while CORDIC busy");

endmodule

### rtl/core/aamm_emit.sv
module aamm_emit
    import aamm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mat_t        mat,
    input  logic        mat_valid,
    output logic        busy,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam logic [31:0] ONE_WORD = 32'd1 << FRAC_BITS;

    mat_t        buf_reg;
    logic        busy_reg;
    logic [3:0]  pos_reg;
    logic        ov_reg;
    logic [31:0] ow_reg;
    logic [3:0]  oi_reg;
    logic        ol_reg;
    logic        load, adv;
    logic [31:0] w;

    assign busy = busy_reg;
    assign load = mat_valid && !busy_reg;
    assign adv  = busy_reg && (!ov_reg || m_axis_tready);

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'd0, oi_reg, ow_reg};
    assign m_axis_tlast  = ol_reg;

    always_comb
    begin
        unique case (pos_reg)
            4'd0:  w = buf_reg.rot[0];
            4'd1:  w = buf_reg.rot[1];
            4'd2:  w = buf_reg.rot[2];
            4'd3:  w = '0;
            4'd4:  w = buf_reg.rot[3];
            4'd5:  w = buf_reg.rot[4];
            4'd6:  w = buf_reg.rot[5];
            4'd7:  w = '0;
            4'd8:  w = buf_reg.rot[6];
            4'd9:  w = buf_reg.rot[7];
            4'd10: w = buf_reg.rot[8];
            4'd11: w = '0;
            4'd12: w = buf_reg.shift[0];
            4'd13: w = buf_reg.shift[1];
            4'd14: w = buf_reg.shift[2];
            4'd15: w = ONE_WORD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= mat;
        end
        if (adv)
        begin
            ow_reg <= w;
            oi_reg <= pos_reg;
            ol_reg <= (pos_reg == LAST_POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 4'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= 4'd0;
            end
            if (adv)
            begin
                ov_reg  <= 1'b1;
                pos_reg <= pos_reg + 4'd1;
                if (pos_reg == LAST_POS)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (ov_reg && m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oi_reg != LAST_POS) |-> busy_reg)
        else $error("matrix released before its last word");

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> (pos_reg == 4'd0))
        else $error("matrix started at nonzero position");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && m_axis_tready && oi_reg != LAST_POS)
        |=> (ov_reg && oi_reg == $past(oi_reg) + 4'd1))
        else $error("gap or skip in element sequence");

endmodule

### rtl/core/axis_angle_model_matrix.sv
// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: rot_angle, axis_x..z, shift_x..z
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: matrix_word, element_index; tlast
//
// Each request yields sixteen words in row-major order, tlast on the sixteenth.
// The engine runs a 32-step square root and 31-step divide lanes, both skipped for a zero
// axis; emission of sixteen words overlaps the engine's work on the next request.
// Reset (rst_n, asynchronous, active low) empties the request queue and idles the engine
// and emitter; matrix payload registers are not cleared.
// A two-deep queue decouples input from the engine; the emitter holds a full matrix and an
// output register, so either side may stall without stopping the other.
module axis_angle_model_matrix
    import aamm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // rot_angle[31:0], axis_x[63:32], axis_y[95:64], axis_z[127:96],
    // shift_x[159:128], shift_y[191:160], shift_z[223:192]
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // matrix_word[31:0], element_index[35:32], zero pad[39:36]
    output logic [39:0]  m_axis_tdata,
    // last_word
    output logic         m_axis_tlast
);

    item_t item;
    logic  item_valid;
    logic  item_take;
    mat_t  mat;
    logic  mat_valid;
    logic  emit_busy;

    // front end: splits fields, takes magnitudes, queues requests
    aamm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item          (item),
        .item_valid    (item_valid),
        .item_take     (item_take)
    );

    // engine: phase, CORDIC, axis normalisation, rotation terms
    aamm_engine #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .mat        (mat),
        .mat_valid  (mat_valid),
        .emit_busy  (emit_busy)
    );

    // emitter: streams the sixteen words through an output register
    aamm_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .mat           (mat),
        .mat_valid     (mat_valid),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### bench/axis_angle_model_matrix_tb.sv
`timescale 1ns / 100ps

module axis_angle_model_matrix_tb
    import aamm_pkg::*;
();

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int STEPS = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;
    localparam int N_RANDOM = 430;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic [31:0]        sx;
        logic [31:0]        sy;
        logic [31:0]        sz;
    } pose_t;

    typedef struct {
        logic [31:0] word;
        logic [3:0]  index;
        logic        last;
    } element_t;

    int n_errors = 0;
    int n_requests = 0;
    int n_words = 0;

    task automatic report(input string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------------
    // Fixed-point matrix predictor
    // ---------------------------------------------------------------------
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= r + bit_w)
            begin
                v -= r + bit_w;
                r = (r >> 1) + bit_w;
            end
            else
                r >>= 1;
            bit_w >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] deg_to_phase(input logic signed [31:0] deg);
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned t;
        logic [31:0] p;
        mag = (deg < 0) ? longint'(-longint'(deg)) : longint'(deg);
        hi = mag * (TURN_CQ >> 32);
        lo = mag * {32'd0, TURN_CQ[31:0]};
        t = hi + (lo >> 32);
        p = 32'((t + (64'd1 << (FRAC - 1))) >> FRAC);
        if (deg < 0)
            p = -p;
        return p;
    endfunction

    function automatic void cordic(input logic [31:0] p, output longint sn,
                                   output longint cs);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        z = longint'($signed(p));
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30))
        begin
            z += (z > 0) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint unit_component(input longint a, input longint unsigned len);
        longint unsigned mag;
        longint q;
        mag = longint'(a < 0 ? -a : a) << 30;
        q = longint'((mag + len / 2) / len);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic [31:0] q30_to_word(input longint v);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? -v : v;
        r = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        if (v < 0)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return -(32'(r));
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return 32'(r);
    endfunction

    function automatic void model_matrix(input pose_t p, output logic [31:0] m16[16]);
        longint ax, ay, az, x, y, z, sn, cs, omc, t, ab, bc, ca, xs, ys, zs;
        longint unsigned mx, my, mz, s, r;
        longint m[9];
        ax = p.ax; ay = p.ay; az = p.az;
        x = 0; y = 0; z = 0;
        mx = (ax < 0) ? -ax : ax;
        my = (ay < 0) ? -ay : ay;
        mz = (az < 0) ? -az : az;
        if (my > mx) mx = my;
        if (mz > mx) mx = mz;
        if (mx != 0)
        begin
            // pre-scale so the largest component reaches 2^30
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1; ax *= 2; ay *= 2; az *= 2;
            end
            s = ax * ax + ay * ay + az * az;
            r = root_floor(s);
            if (s - r * r > r)
                r += 1;
            x = unit_component(ax, r);
            y = unit_component(ay, r);
            z = unit_component(az, r);
        end
        cordic(deg_to_phase(p.angle), sn, cs);
        omc = longint'(ONE_Q30) - cs;
        ab = q30_mul(q30_mul(x, y), omc);
        bc = q30_mul(q30_mul(y, z), omc);
        ca = q30_mul(q30_mul(z, x), omc);
        xs = q30_mul(x, sn); ys = q30_mul(y, sn); zs = q30_mul(z, sn);
        t = q30_mul(x, x); m[0] = t + q30_mul(cs, longint'(ONE_Q30) - t);
        t = q30_mul(y, y); m[4] = t + q30_mul(cs, longint'(ONE_Q30) - t);
        t = q30_mul(z, z); m[8] = t + q30_mul(cs, longint'(ONE_Q30) - t);
        m[1] = ab + zs; m[3] = ab - zs;
        m[2] = ca - ys; m[6] = ca + ys;
        m[5] = bc + xs; m[7] = bc - xs;
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int c = 0; c < 3; c++)
                m16[rr * 4 + c] = q30_to_word(m[rr * 3 + c]);
            m16[rr * 4 + 3] = '0;
        end
        m16[12] = p.sx; m16[13] = p.sy; m16[14] = p.sz;
        m16[15] = 32'd1 << FRAC;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: queue of expected matrix elements
    // ---------------------------------------------------------------------
    class matrix_scoreboard;
        element_t pending[$];

        function void note_request(input pose_t p);
            logic [31:0] m16[16];
            element_t e;
            model_matrix(p, m16);
            for (int k = 0; k < 16; k++)
            begin
                e.word = m16[k];
                e.index = 4'(k);
                e.last = (4'(k) == LAST_POS);
                pending.push_back(e);
            end
        endfunction

        task check_word(input logic [39:0] data, input logic last);
            element_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word %h", data));
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.word)
                report($sformatf("element %0d word %h, want %h", e.index, data[31:0], e.word));
            if (data[35:32] !== e.index)
                report($sformatf("index %0d, want %0d", data[35:32], e.index));
            if (data[39:36] !== 4'd0)
                report($sformatf("element %0d pad bits %h", e.index, data[39:36]));
            if (last !== e.last)
                report($sformatf("element %0d tlast %b", e.index, last));
        endtask
    endclass

    matrix_scoreboard sb;

    // ---------------------------------------------------------------------
    // DUT and clocking
    // ---------------------------------------------------------------------
    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tlast;

    axis_angle_model_matrix u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver behaviour: random gaps, plus one long hold-off on request
    bit hold_sink = 0;
    bit sink_quiet = 0;      // no random gaps at all
    int sink_gap = 0;

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_word(m_axis_tdata, m_axis_tlast);
                n_words++;
                sink_gap = sink_quiet ? 0 : $urandom_range(0, 12);
            end
            if (hold_sink)
                m_axis_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------------
    bit src_quiet = 0;

    // valid stays high between back-to-back requests; a gap drops it first
    task automatic send_request(input pose_t p);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.sz, p.sy, p.sx, p.az, p.ay, p.ax, p.angle};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(p);
        n_requests++;
    endtask

    // withdraw valid once a batch of requests is done
    task automatic stop_source();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        // mix of full range, small values and extremes
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 24'h7F_FFFF)) - 32'sh40_0000);
            3: return 32'($signed($urandom_range(0, 720 << 8)) - (360 << 8)) << 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        p.angle = rand_word();
        p.ax = rand_word(); p.ay = rand_word(); p.az = rand_word();
        // sometimes zero or single-axis rotation
        case ($urandom_range(0, 9))
            0: begin p.ax = 0; p.ay = 0; p.az = 0; end
            1: begin p.ay = 0; p.az = 0; end
            2: begin p.ax = 0; p.az = 0; end
            default: ;
        endcase
        p.sx = $urandom(); p.sy = $urandom(); p.sz = $urandom();
        return p;
    endfunction

    function automatic pose_t mk(input logic [31:0] a, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z);
        pose_t p;
        p.angle = a; p.ax = x; p.ay = y; p.az = z;
        p.sx = $urandom(); p.sy = $urandom(); p.sz = $urandom();
        return p;
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial
    begin
        pose_t p;
        int hold;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cardinal angles, zero axis, extremes, wrap by whole turns
        send_request(mk(32'd0, ONE, 0, 0));
        send_request(mk(90 * ONE, 0, 0, ONE));
        send_request(mk(-90 * ONE, 0, ONE, 0));
        send_request(mk(180 * ONE, ONE, ONE, ONE));
        send_request(mk(270 * ONE, ONE, 0, 0));
        send_request(mk(45 * ONE, 0, 0, 0));
        send_request(mk(30 * ONE, 0, 0, 0));
        send_request(mk(720 * ONE + 30 * ONE, 0, 0, ONE));
        send_request(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_request(mk(32'd1, 32'd1, 0, 0));
        send_request(mk(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
        send_request(mk(60 * ONE, 32'd3, 32'hFFFF_FFFB, 32'd7));
        send_request(mk(120 * ONE, 32'h4000_0000, 32'h4000_0000, 0));
        send_request(mk(-45 * ONE, ONE, 32'hFFFF_0000, ONE));
        p = mk(32'h8000_0000, 0, 0, 0);
        p.sx = 32'h8000_0000; p.sy = 32'h7FFF_FFFF; p.sz = 32'hFFFF_FFFF;
        send_request(p);
        p = mk(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        p.sx = 0; p.sy = 32'h5555_5555; p.sz = 32'hAAAA_AAAA;
        send_request(p);
        stop_source();

        // sender pause: wait for every outstanding word
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_sink = 1;
                for (hold = 0; hold < 400; hold++)
                    @(posedge clk);
                hold_sink = 0;
            end
            begin
                src_quiet = 1;
                repeat (10) send_request(rand_pose());
                stop_source();
                src_quiet = 0;
            end
        join

        // random traffic, with a burst of back-to-back, no-gap operation
        for (int i = 0; i < N_RANDOM; i++)
        begin
            src_quiet = (i >= 100 && i < 160);
            sink_quiet = (i >= 100 && i < 160);
            send_request(rand_pose());
        end
        stop_source();
        src_quiet = 0;
        sink_quiet = 0;

        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d matrix requests, %0d words checked, incl. zero axis,",
                 n_requests, n_words);
        $display("extreme angles and axes, long output back-pressure and idle gaps.");
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: bounds the run for ~460 requests with random output stalls, with a wide margin
    initial
    begin
        #20ms;
        $display("Timeout with %0d words outstanding", sb.pending.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
